// ----- rtl/bounded_deque_unit_macros.svh -----
// ----------------------------------------------------------------------------
// bounded deque unit assertion macros
// shared concurrent assertion forms, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_UNIT_MACROS_SVH

`ifndef SYNTH
// property holds at every edge outside reset
`define BDU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bounded deque assertion failed");
// consequent holds in the cycle after the antecedent
`define BDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded deque assertion failed");
`else
`define BDU_ASSERT(lbl, clk, rst_n, prop)
`define BDU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// types and constants of the bounded deque unit
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // command with at most one bit set, broadcast to every cell of the row
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cell_cmd_t;

endpackage

// ----- rtl/bounded_deque_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_unit
// fixed-capacity double-ended queue of signed 32-bit values
// ----------------------------------------------------------------------------
// The deque is a row of CAPACITY cells, cell 0 holding the front element and
// the occupied cells forming a contiguous run from cell 0. A push at the front
// shifts the whole row one cell toward the rear, a pop at the front shifts it
// one cell toward the front; a push at the rear fills the first free cell and
// a pop at the rear frees the last occupied one, whose word reaches the output
// through a one-hot select over the cells. An item is accepted in any cycle
// where the output register is empty or its result is being transferred, so
// one item per clock is sustained, and each result is registered and appears
// in the cycle after its item. A push to a full deque is refused
// with status full, a pop from an empty deque with status empty; both return
// 0 and leave the contents alone. Every result carries the element count
// after the operation, cut to 5 bits. Cells that were never written hold
// arbitrary data, but no pop ever reads them.
// ----------------------------------------------------------------------------
module bounded_deque_unit import bdq_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] popped_value_o,
  output logic [1:0]         status_o,
  output logic [4:0]         element_count_o
);

`include "bounded_deque_unit_macros.svh"

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // row of cells
  logic [DataW-1:0] cell_data [CAPACITY];
  logic [DataW-1:0] front_data [CAPACITY];
  logic [DataW-1:0] rear_data [CAPACITY];
  logic [CAPACITY-1:0] cell_occ, front_occ, rear_occ, cell_tail;
  cell_cmd_t cmd;

  // element count and output register
  logic [CntW-1:0]  count_q, count_d, count_nxt;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] popped_q, popped_d, rear_val;
  status_e          status_q, status_d;
  logic [CntW-1:0]  count_out_q;
  logic [CntW+CountW-1:0] count_ext;

  logic in_fire, full, empty;
  op_e  op;

  // accept while the output slot is free or drains this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign op         = op_e'(op_i);
  assign empty      = (count_q == '0);
  assign full       = (count_q == CntW'(CAPACITY));

  // neighbor wiring: cell 0 sees the new value in front, the last cell sees nothing behind
  for (genvar i = 0; i < CAPACITY; i++) begin : g_row
    if (i == 0) begin : g_first
      assign front_data[i] = push_value_i;
      assign front_occ[i]  = 1'b1;
    end else begin : g_inner
      assign front_data[i] = cell_data[i-1];
      assign front_occ[i]  = cell_occ[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rear_data[i] = '0;
      assign rear_occ[i]  = 1'b0;
    end else begin : g_body
      assign rear_data[i] = cell_data[i+1];
      assign rear_occ[i]  = cell_occ[i+1];
    end

    bdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .push_value_i (push_value_i),
      .front_data_i (front_data[i]),
      .front_occ_i  (front_occ[i]),
      .rear_data_i  (rear_data[i]),
      .rear_occ_i   (rear_occ[i]),
      .data_o       (cell_data[i]),
      .occ_o        (cell_occ[i]),
      .tail_o       (cell_tail[i])
    );
  end

  // rear element: exactly one cell flags itself as tail when the deque is not empty
  always_comb begin
    rear_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_tail[i]) begin
        rear_val = rear_val | cell_data[i];
      end
    end
  end

  // decode the operation; the row only moves on a transfer that succeeds
  always_comb begin
    cmd       = '0;
    status_d  = ST_DONE;
    popped_d  = '0;
    count_nxt = count_q;
    case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.push_front = in_fire;
          count_nxt      = count_q + CntW'(1);
        end
      end
      OP_PUSH_REAR: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.push_rear = in_fire;
          count_nxt     = count_q + CntW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.pop_front = in_fire;
          popped_d      = cell_data[0];
          count_nxt     = count_q - CntW'(1);
        end
      end
      OP_POP_REAR: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.pop_rear = in_fire;
          popped_d     = rear_val;
          count_nxt    = count_q - CntW'(1);
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  assign count_d     = in_fire ? count_nxt : count_q;
  assign out_valid_d = in_fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded on every accepted item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      popped_q    <= popped_d;
      status_q    <= status_d;
      count_out_q <= count_nxt;
    end
  end

  // count reported in 5 bits whatever the internal width
  assign count_ext = {{CountW{1'b0}}, count_out_q};

  assign out_valid_o     = out_valid_q;
  assign popped_value_o  = popped_q;
  assign status_o        = status_q;
  assign element_count_o = count_ext[CountW-1:0];

  // the number of occupied flags equals the count
  `BDU_ASSERT(a_occ_matches_count, clk_i, rst_ni,
              $countones(cell_occ) == int'(count_q))
  // count never passes the capacity
  `BDU_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(CAPACITY))
  // a refused push leaves count and occupancy alone and reports full
  `BDU_ASSERT_NEXT(a_full_refuse, clk_i, rst_ni,
                   in_fire && full && (op == OP_PUSH_FRONT || op == OP_PUSH_REAR),
                   $stable(count_q) && $stable(cell_occ) && status_q == ST_FULL)
  // a front pop returns what cell 0 held
  `BDU_ASSERT_NEXT(a_pop_front_value, clk_i, rst_ni,
                   in_fire && !empty && op == OP_POP_FRONT,
                   popped_q == $past(cell_data[0]))

endmodule

// ----- rtl/bdq_cell.sv -----
// ----------------------------------------------------------------------------
// bdq_cell
// one position of the deque row: a data word and an occupied flag
// ----------------------------------------------------------------------------
module bdq_cell import bdq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cmd_t        cmd_i,
  input  logic [DataW-1:0] push_value_i,
  input  logic [DataW-1:0] front_data_i,
  input  logic             front_occ_i,
  input  logic [DataW-1:0] rear_data_i,
  input  logic             rear_occ_i,
  output logic [DataW-1:0] data_o,
  output logic             occ_o,
  output logic             tail_o
);

  logic [DataW-1:0] data_q, data_d;
  logic             occ_q, occ_d;
  logic             tail;

  // last occupied cell of the row
  assign tail = occ_q && !rear_occ_i;

  always_comb begin
    data_d = data_q;
    occ_d  = occ_q;
    if (cmd_i.push_front) begin
      data_d = front_data_i;
      occ_d  = front_occ_i;
    end else if (cmd_i.push_rear) begin
      if (front_occ_i && !occ_q) begin
        data_d = push_value_i;
        occ_d  = 1'b1;
      end
    end else if (cmd_i.pop_front) begin
      data_d = rear_data_i;
      occ_d  = rear_occ_i;
    end else if (cmd_i.pop_rear) begin
      if (tail) begin
        occ_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign occ_o  = occ_q;
  assign tail_o = tail;

endmodule
